FILE: design/mafd_pkg.sv
// Shared types, codes and the CRC-8 step for the mux frame deframer.
// No dependencies; used by the front end, back end and top level of the block.
package mafd_pkg;

  // One received beat as it arrives on the input side.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       line_error;
  } rx_item_t;

  // One result beat on the output side.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       kind;
    logic [2:0] frame_status;
  } result_t;

  // Received beat after the front end has matched it against flag and escape.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       line_error;
    logic       is_flag;
    logic       is_esc;
  } cls_item_t;

  localparam logic [1:0] CFG_FLAG_BYTE   = 2'd0;
  localparam logic [1:0] CFG_ESCAPE_BYTE = 2'd1;
  localparam logic [1:0] CFG_HEADER_LEN  = 2'd2;
  localparam logic [1:0] CFG_MAX_LEN     = 2'd3;

  localparam logic [7:0] FLAG_RESET    = 8'h7E;
  localparam logic [7:0] ESCAPE_RESET  = 8'h7D;
  localparam logic [2:0] HDR_LEN_RESET = 3'd2;
  localparam logic [9:0] MAX_LEN_RESET = 10'd128;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [2:0] ST_GOOD      = 3'd0;
  localparam logic [2:0] ST_BAD_FCS   = 3'd1;
  localparam logic [2:0] ST_TOO_SHORT = 3'd2;
  localparam logic [2:0] ST_TOO_LONG  = 3'd3;
  localparam logic [2:0] ST_ABORTED   = 3'd4;

  localparam logic [7:0] CRC_INIT    = 8'hFF;
  localparam logic [7:0] CRC_RESIDUE = 8'hCF;
  localparam logic [7:0] CRC_POLY    = 8'hE0;  // reflected x^8+x^2+x+1
  localparam logic [7:0] ESC_XOR     = 8'h20;

  // One byte through the reflected CRC-8, eight shift steps.
  function automatic logic [7:0] crc8_step(input logic [7:0] v);
    logic [7:0] c;
    c = v;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: design/mafd_queue.sv
// Small register-based FIFO, generic width and depth.
// No package dependencies; used for the front and back queues.
module mafd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_wr, do_rd})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

FILE: design/mafd_front.sv
// Front end: takes raw beats, tags flag and escape matches, queues them.
// Depends on mafd_pkg and mafd_queue.
module mafd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          flag_byte_i,
  input  logic [7:0]          escape_byte_i,
  input  logic                push_i,
  input  mafd_pkg::rx_item_t  item_i,
  output logic                full_o,
  input  logic                rd_i,
  output mafd_pkg::cls_item_t cls_o,
  output logic                empty_o
);

  mafd_pkg::cls_item_t cls_in;

  always_comb begin
    cls_in.rx_byte    = item_i.rx_byte;
    cls_in.line_error = item_i.line_error;
    cls_in.is_flag    = (item_i.rx_byte == flag_byte_i);
    cls_in.is_esc     = (item_i.rx_byte == escape_byte_i);
  end

  mafd_queue #(
    .WIDTH($bits(mafd_pkg::cls_item_t)),
    .DEPTH(2)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (push_i),
    .wdata_i(cls_in),
    .full_o (full_o),
    .rd_i   (rd_i),
    .rdata_o(cls_o),
    .empty_o(empty_o)
  );

endmodule

FILE: design/mafd_back.sv
// Back end: deframer state (phase, escape, count, CRC) and the result queue.
// Depends on mafd_pkg and mafd_queue.
module mafd_back #(
  parameter int MAX_LENGTH_BITS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [2:0]          header_len_i,
  input  logic [9:0]          max_len_i,
  input  mafd_pkg::cls_item_t cls_i,
  input  logic                cls_empty_i,
  output logic                cls_rd_o,
  input  logic                pop_i,
  output mafd_pkg::result_t   res_o,
  output logic                empty_o
);

  localparam int CW = ((MAX_LENGTH_BITS > 10) ? MAX_LENGTH_BITS : 10) + 1;
  localparam logic [CW-1:0] Cap = CW'((2 ** MAX_LENGTH_BITS) - 1);

  localparam logic [1:0] PH_HUNT  = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_DATA  = 2'd2;

  logic [1:0]                 phase_q, phase_d;
  logic                       esc_q, esc_d;
  logic [MAX_LENGTH_BITS-1:0] count_q, count_d;
  logic [7:0]                 acc_q, acc_d;
  logic [7:0]                 last_q, last_d;

  logic              out_full, fire, res_wr;
  mafd_pkg::result_t res;
  logic [7:0]        b;
  logic [CW-1:0]     limit, cnt_ext, hdr_ext;
  logic              go_data;

  assign fire     = !cls_empty_i && !out_full;
  assign cls_rd_o = fire;
  assign cnt_ext  = CW'(count_q);
  assign hdr_ext  = CW'(header_len_i);
  assign limit    = (CW'(max_len_i) < Cap) ? CW'(max_len_i) : Cap;

  always_comb begin
    phase_d  = phase_q;
    esc_d    = esc_q;
    count_d  = count_q;
    acc_d    = acc_q;
    last_d   = last_q;
    res_wr   = 1'b0;
    res      = '0;
    b        = cls_i.rx_byte;
    go_data  = 1'b0;
    if (fire) begin
      if (cls_i.line_error) begin
        res_wr             = (phase_q == PH_DATA);
        res.kind           = mafd_pkg::KIND_END;
        res.frame_status   = mafd_pkg::ST_ABORTED;
        phase_d            = PH_HUNT;
        esc_d              = 1'b0;
        count_d            = '0;
        acc_d              = mafd_pkg::CRC_INIT;
        last_d             = '0;
      end else if (phase_q == PH_HUNT) begin
        if (esc_q) begin
          esc_d = 1'b0;
        end else if (cls_i.is_esc) begin
          esc_d = 1'b1;
        end else if (cls_i.is_flag) begin
          phase_d = PH_START;
          count_d = '0;
          acc_d   = mafd_pkg::CRC_INIT;
          last_d  = '0;
        end
      end else if (esc_q) begin
        b       = cls_i.rx_byte ^ mafd_pkg::ESC_XOR;
        esc_d   = 1'b0;
        go_data = 1'b1;
      end else if (cls_i.is_esc) begin
        esc_d = 1'b1;
      end else if (cls_i.is_flag) begin
        // closing flag also opens the next frame
        if (phase_q == PH_DATA) begin
          res_wr   = 1'b1;
          res.kind = mafd_pkg::KIND_END;
          if (cnt_ext > hdr_ext) begin
            res.frame_status = (mafd_pkg::crc8_step(acc_q ^ last_q) == mafd_pkg::CRC_RESIDUE)
                             ? mafd_pkg::ST_GOOD : mafd_pkg::ST_BAD_FCS;
          end else begin
            res.frame_status = mafd_pkg::ST_TOO_SHORT;
          end
          phase_d = PH_START;
          count_d = '0;
          acc_d   = mafd_pkg::CRC_INIT;
          last_d  = '0;
        end
      end else begin
        go_data = 1'b1;
      end

      if (go_data) begin
        res_wr = 1'b1;
        if (cnt_ext + 1'b1 > limit) begin
          res.kind         = mafd_pkg::KIND_END;
          res.frame_status = mafd_pkg::ST_TOO_LONG;
          phase_d          = PH_HUNT;
          esc_d            = 1'b0;
          count_d          = '0;
          acc_d            = mafd_pkg::CRC_INIT;
          last_d           = '0;
        end else begin
          res.out_byte     = b;
          res.kind         = mafd_pkg::KIND_DATA;
          res.frame_status = mafd_pkg::ST_GOOD;
          phase_d          = PH_DATA;
          if (cnt_ext < hdr_ext) begin
            acc_d = mafd_pkg::crc8_step(acc_q ^ b);
          end
          last_d  = b;
          count_d = count_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      esc_q   <= 1'b0;
      count_q <= '0;
      acc_q   <= mafd_pkg::CRC_INIT;
      last_q  <= '0;
    end else begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      count_q <= count_d;
      acc_q   <= acc_d;
      last_q  <= last_d;
    end
  end

  mafd_queue #(
    .WIDTH($bits(mafd_pkg::result_t)),
    .DEPTH(2)
  ) u_out_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (res_wr),
    .wdata_i(res),
    .full_o (out_full),
    .rd_i   (pop_i),
    .rdata_o(res_o),
    .empty_o(empty_o)
  );

endmodule

FILE: design/mux_advanced_frame_deframer.sv
// Top level of the mux frame deframer: config registers, front and back ends.
// Depends on mafd_pkg, mafd_front, mafd_back (and mafd_queue below them).
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------------
//   input    | push / full         | in_data_i  (rx_byte, line_error)
//   result   | empty / pop         | out_data_o (out_byte, kind, status)
//   config   | cfg_we_i            | cfg_idx_i, cfg_data_i
//
// One beat per cycle while the result side keeps up; a result beat is first
// registered in the front queue, then the back-end state update writes it into
// the result queue, which drives the output. Two-entry queues on each side let
// the front keep taking beats while a result waits for pop. Reset clears all
// state; config returns to flag 0x7E, escape 0x7D, header length 2, max length 128.
module mux_advanced_frame_deframer #(
  parameter int MAX_LENGTH_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  mafd_pkg::rx_item_t in_data_i,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output mafd_pkg::result_t  out_data_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [9:0]         cfg_data_i
);

  logic [7:0] flag_q, esc_byte_q;
  logic [2:0] hdr_len_q;
  logic [9:0] max_len_q;

  mafd_pkg::cls_item_t cls;
  logic                cls_empty, cls_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q     <= mafd_pkg::FLAG_RESET;
      esc_byte_q <= mafd_pkg::ESCAPE_RESET;
      hdr_len_q  <= mafd_pkg::HDR_LEN_RESET;
      max_len_q  <= mafd_pkg::MAX_LEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mafd_pkg::CFG_FLAG_BYTE:   flag_q     <= cfg_data_i[7:0];
        mafd_pkg::CFG_ESCAPE_BYTE: esc_byte_q <= cfg_data_i[7:0];
        mafd_pkg::CFG_HEADER_LEN:  hdr_len_q  <= cfg_data_i[2:0];
        mafd_pkg::CFG_MAX_LEN:     max_len_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mafd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .flag_byte_i  (flag_q),
    .escape_byte_i(esc_byte_q),
    .push_i       (push),
    .item_i       (in_data_i),
    .full_o       (full),
    .rd_i         (cls_rd),
    .cls_o        (cls),
    .empty_o      (cls_empty)
  );

  mafd_back #(
    .MAX_LENGTH_BITS(MAX_LENGTH_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .header_len_i(hdr_len_q),
    .max_len_i   (max_len_q),
    .cls_i       (cls),
    .cls_empty_i (cls_empty),
    .cls_rd_o    (cls_rd),
    .pop_i       (pop),
    .res_o       (out_data_o),
    .empty_o     (empty)
  );

endmodule

FILE: verif/mafd_checker.sv
// Scoreboard for the mux frame deframer: a CRC helper package and a module that
// predicts every result beat from accepted input beats and compares. Needs mafd_pkg.
package mafd_tb_pkg;
  import mafd_pkg::*;

  // Running reflected CRC-8: fold one octet into the accumulator.
  function automatic logic [7:0] crc_fold(input logic [7:0] acc, input logic [7:0] octet);
    logic [7:0] c;
    c = acc ^ octet;
    repeat (8) c = {1'b0, c[7:1]} ^ (c[0] ? CRC_POLY : 8'h00);
    return c;
  endfunction
endpackage

module mafd_checker
  import mafd_pkg::*;
  import mafd_tb_pkg::*;
#(
  parameter int MAX_LENGTH_BITS = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic       full_i,
  input  rx_item_t   in_data_i,
  input  logic       empty_i,
  input  logic       pop_i,
  input  result_t    out_data_i,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [9:0] cfg_data_i,
  output int         mismatch_o,
  output int         pending_o
);

  typedef enum logic [1:0] {PH_HUNT, PH_OPENED, PH_IN_DATA} link_phase_e;

  link_phase_e phase;
  logic        esc_pend;
  int unsigned byte_count;
  logic [7:0]  crc_acc;
  logic [7:0]  fcs_byte;

  logic [7:0]  cfg_flag;
  logic [7:0]  cfg_esc;
  logic [2:0]  cfg_hdr;
  logic [9:0]  cfg_max_len;

  result_t     deframed_q[$];
  int          mismatch_count;

  function automatic void restart_frame();
    byte_count = 0;
    crc_acc    = CRC_INIT;
    fcs_byte   = 8'h00;
  endfunction

  // Advances the deframer state by one beat; returns 1 when a result beat is due.
  function automatic bit deframe_beat(input rx_item_t it, output result_t res);
    logic [7:0]  b;
    int unsigned cap;
    int unsigned limit;
    bit          was_data;
    res   = '0;
    b     = it.rx_byte;
    cap   = (1 << MAX_LENGTH_BITS) - 1;
    limit = (cfg_max_len < cap) ? cfg_max_len : cap;

    if (it.line_error) begin
      was_data = (phase == PH_IN_DATA);
      phase    = PH_HUNT;
      esc_pend = 1'b0;
      restart_frame();
      res.kind         = KIND_END;
      res.frame_status = ST_ABORTED;
      return was_data;
    end

    if (phase == PH_HUNT) begin
      if (esc_pend) begin
        esc_pend = 1'b0;
      end else if (b == cfg_esc) begin
        esc_pend = 1'b1;
      end else if (b == cfg_flag) begin
        phase = PH_OPENED;
        restart_frame();
      end
      return 1'b0;
    end

    // escape wins over flag when both registers hold the same value
    if (esc_pend) begin
      b        = b ^ ESC_XOR;
      esc_pend = 1'b0;
    end else if (b == cfg_esc) begin
      esc_pend = 1'b1;
      return 1'b0;
    end else if (b == cfg_flag) begin
      if (phase != PH_IN_DATA) return 1'b0;
      res.kind = KIND_END;
      if (byte_count > cfg_hdr) begin
        res.frame_status = (crc_fold(crc_acc, fcs_byte) == CRC_RESIDUE) ? ST_GOOD : ST_BAD_FCS;
      end else begin
        res.frame_status = ST_TOO_SHORT;
      end
      phase = PH_OPENED;
      restart_frame();
      return 1'b1;
    end

    if (byte_count + 1 > limit) begin
      phase    = PH_HUNT;
      esc_pend = 1'b0;
      restart_frame();
      res.kind         = KIND_END;
      res.frame_status = ST_TOO_LONG;
      return 1'b1;
    end
    phase = PH_IN_DATA;
    if (byte_count < cfg_hdr) crc_acc = crc_fold(crc_acc, b);
    fcs_byte = b;
    byte_count++;
    res.out_byte = b;
    res.kind     = KIND_DATA;
    return 1'b1;
  endfunction

  function automatic void note_mismatch(string field, int want, int got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mafd_checker: %s mismatch, expected 0x%0h got 0x%0h at %0t",
               field, want, got, $time);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t want;
    result_t due;
    if (!rst_ni) begin
      phase       = PH_HUNT;
      esc_pend    = 1'b0;
      restart_frame();
      cfg_flag    = FLAG_RESET;
      cfg_esc     = ESCAPE_RESET;
      cfg_hdr     = HDR_LEN_RESET;
      cfg_max_len = MAX_LEN_RESET;
      deframed_q.delete();
      mismatch_count = 0;
    end else begin
      if (pop_i && !empty_i) begin
        if (deframed_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mafd_checker: result beat with none expected, got %p at %0t",
                     out_data_i, $time);
          end
        end else begin
          want = deframed_q.pop_front();
          if (out_data_i.out_byte !== want.out_byte)
            note_mismatch("out_byte", want.out_byte, out_data_i.out_byte);
          if (out_data_i.kind !== want.kind)
            note_mismatch("kind", want.kind, out_data_i.kind);
          if (out_data_i.frame_status !== want.frame_status)
            note_mismatch("frame_status", want.frame_status, out_data_i.frame_status);
        end
      end
      if (push_i && !full_i) begin
        if (deframe_beat(in_data_i, due)) deframed_q.push_back(due);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FLAG_BYTE:   cfg_flag    = cfg_data_i[7:0];
          CFG_ESCAPE_BYTE: cfg_esc     = cfg_data_i[7:0];
          CFG_HEADER_LEN:  cfg_hdr     = cfg_data_i[2:0];
          CFG_MAX_LEN:     cfg_max_len = cfg_data_i;
          default: ;
        endcase
      end
    end
    mismatch_o <= mismatch_count;
    pending_o  <= deframed_q.size();
  end

endmodule

FILE: verif/tb_top.sv
// Testbench top for mux_advanced_frame_deframer: clock, reset, frame stimulus,
// config phases and result-side stalls. Depends on mafd_pkg and mafd_checker.
module tb_top;
  import mafd_pkg::*;
  import mafd_tb_pkg::*;

  typedef logic [7:0] octet_q_t[$];

  localparam int CYCLE_LIMIT = 500000;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       push      = 1'b0;
  logic       pop       = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_idx   = CFG_FLAG_BYTE;
  logic [9:0] cfg_data  = '0;
  rx_item_t   in_data   = '0;
  logic       stim_busy = 1'b0;
  logic       full;
  logic       empty;
  result_t    out_data;
  int         mismatches;
  int         pending;
  int         cycles    = 0;

  logic [7:0] cur_flag = FLAG_RESET;
  logic [7:0] cur_esc  = ESCAPE_RESET;
  logic [2:0] cur_hdr  = HDR_LEN_RESET;
  logic [9:0] cur_max  = MAX_LEN_RESET;
  int         burst_left = 0;
  int         beats_sent = 0;
  bit         need_open  = 1'b1;

  always #10 clk_i = ~clk_i;

  mux_advanced_frame_deframer #(.MAX_LENGTH_BITS(10)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .in_data_i  (in_data),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  mafd_checker #(.MAX_LENGTH_BITS(10)) u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_i     (full),
    .in_data_i  (in_data),
    .empty_i    (empty),
    .pop_i      (pop),
    .out_data_i (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .mismatch_o (mismatches),
    .pending_o  (pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Result side: random pop rate that changes now and then, plus long holds
  // while stimulus is running so the queues back up into full.
  initial begin : receiver
    int pct;
    int mode_left;
    int hold_left;
    int since_hold;
    pct        = 100;
    mode_left  = 0;
    hold_left  = 0;
    since_hold = 2000;
    forever begin
      @(posedge clk_i);
      since_hold++;
      if (hold_left == 0 && stim_busy && since_hold >= 2000) begin
        hold_left  = $urandom_range(250, 400);
        since_hold = 0;
      end
      if (mode_left == 0) begin
        case ($urandom_range(0, 4))
          0, 1:    pct = 100;
          2:       pct = 60;
          3:       pct = 30;
          default: pct = 10;
        endcase
        mode_left = $urandom_range(20, 400);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(1, 100) <= pct);
      end
    end
  end

  // One input beat; bursts of random length with random gaps in between.
  task automatic send_octet(logic [7:0] octet, logic err);
    int       gap;
    rx_item_t it;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 16) : $urandom_range(0, 2);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 12);
    end
    it.rx_byte    = octet;
    it.line_error = err;
    push    <= 1'b1;
    in_data <= it;
    do @(posedge clk_i); while (full);
    burst_left--;
    beats_sent++;
  endtask

  task automatic send_stuffed(logic [7:0] octet);
    if (octet == cur_flag || octet == cur_esc || $urandom_range(0, 19) == 0) begin
      send_octet(cur_esc, 1'b0);
      send_octet(octet ^ ESC_XOR, 1'b0);
    end else begin
      send_octet(octet, 1'b0);
    end
  endtask

  function automatic logic [7:0] random_octet();
    case ($urandom_range(0, 7))
      0:       return cur_flag;
      1:       return cur_esc;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Replaces the last byte with an FCS that passes, or one bit off when bad.
  function automatic octet_q_t seal(octet_q_t body, bit good);
    logic [7:0] acc;
    logic [7:0] fcs;
    if (body.size() > cur_hdr) begin
      acc = CRC_INIT;
      for (int i = 0; i < cur_hdr; i++) acc = crc_fold(acc, body[i]);
      fcs = 8'h00;
      for (int v = 0; v < 256; v++) begin
        if (crc_fold(acc, 8'(v)) == CRC_RESIDUE) fcs = 8'(v);
      end
      if (!good) fcs = fcs ^ 8'(1 << $urandom_range(0, 7));
      body[body.size() - 1] = fcs;
    end
    return body;
  endfunction

  // Stuffed body and closing flag; a line error replaces beat abort_at if given.
  task automatic send_body(octet_q_t body, int abort_at);
    for (int i = 0; i <= body.size(); i++) begin
      if (i == abort_at) begin
        send_octet(8'($urandom_range(0, 255)), 1'b1);
        need_open = 1'b1;
        return;
      end
      if (i < body.size()) send_stuffed(body[i]);
    end
    send_octet(cur_flag, 1'b0);
    need_open = 1'b0;
  endtask

  task automatic send_frame(int len, bit good, int abort_at);
    octet_q_t body;
    int       opens;
    body = {};
    for (int i = 0; i < len; i++) body.push_back(random_octet());
    body  = seal(body, good);
    opens = need_open ? $urandom_range(1, 2) : $urandom_range(0, 1);
    repeat (opens) send_octet(cur_flag, 1'b0);
    send_body(body, abort_at);
  endtask

  task automatic write_config(logic [7:0] f, logic [7:0] e, logic [2:0] h, logic [9:0] m);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_FLAG_BYTE;
    cfg_data <= {2'b00, f};
    @(posedge clk_i);
    cfg_idx  <= CFG_ESCAPE_BYTE;
    cfg_data <= {2'b00, e};
    @(posedge clk_i);
    cfg_idx  <= CFG_HEADER_LEN;
    cfg_data <= {7'd0, h};
    @(posedge clk_i);
    cfg_idx  <= CFG_MAX_LEN;
    cfg_data <= m;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    cur_flag = f;
    cur_esc  = e;
    cur_hdr  = h;
    cur_max  = m;
  endtask

  // Wait for every expected beat, then let beats with no result clear the pipe.
  task automatic drain();
    push <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic directed_frames();
    octet_q_t body;
    send_octet(8'h00, 1'b0);
    send_octet(8'hFF, 1'b0);
    send_octet(cur_esc, 1'b0);   // escaped flag while hunting is dropped
    send_octet(cur_flag, 1'b0);
    send_octet(8'h5A, 1'b1);     // line error while hunting
    send_octet(cur_flag, 1'b0);
    send_octet(cur_flag, 1'b0);  // repeated opening flag
    body = '{8'h7E, 8'h7D, 8'h00};
    send_body(seal(body, 1'b1), -1);
    body = '{8'h00, 8'hFF};      // header only
    send_body(body, -1);
    body = '{8'hAA, 8'h55, 8'h12};
    send_body(seal(body, 1'b0), -1);
    send_octet(cur_flag, 1'b0);  // empty frame, no beat out
    body = '{8'h01, 8'h02};
    send_body(body, 2);          // abort inside frame data
    send_octet(cur_flag, 1'b0);
    send_octet(8'h33, 1'b1);     // abort right after opening flag
  endtask

  task automatic run_phase(logic [7:0] f, logic [7:0] e, logic [2:0] h, logic [9:0] m,
                           int target);
    int quota;
    int len;
    int pick;
    drain();
    write_config(f, e, h, m);
    need_open = 1'b1;
    stim_busy <= 1'b1;
    quota = beats_sent + target;
    while (beats_sent < quota) begin
      len  = $urandom_range(0, cur_hdr + 5);
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        send_frame(len, $urandom_range(0, 9) < 6, -1);
      end else if (pick < 82) begin
        send_frame(len, 1'b1, $urandom_range(0, len));
      end else if (pick < 88) begin
        send_octet(8'($urandom_range(0, 255)), 1'b1);
        need_open = 1'b1;
      end else begin
        repeat ($urandom_range(1, 6)) send_octet(random_octet(), 1'b0);
        need_open = 1'b1;
      end
    end
    // one frame past the length limit, kept to the shorter limits
    if (cur_max < 10'd200) send_frame(int'(cur_max) + 1, 1'b1, -1);
    stim_busy <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_frames();
    run_phase(8'h7E, 8'h7D, 3'd2, 10'd128, 120);
    run_phase(8'h7E, 8'h7D, 3'd1, 10'd4, 120);
    run_phase(8'h00, 8'hFF, 3'd4, 10'd1023, 120);
    run_phase(8'hFF, 8'h00, 3'd3, 10'd20, 120);
    run_phase(8'h55, 8'h55, 3'd2, 10'd16, 60);   // flag equals escape
    run_phase(8'h7E, 8'h7D, 3'd0, 10'd9, 120);
    run_phase(8'hA5, 8'h5A, 3'd7, 10'd12, 120);
    run_phase(8'h7E, 8'h7D, 3'd5, 10'd0, 40);
    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
